@@ hdl/lzw_dictionary_table_assert.svh @@
// Assertion macros used by the checker file of the dictionary block.
`ifndef LZW_DICTIONARY_TABLE_ASSERT_SVH
`define LZW_DICTIONARY_TABLE_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define LZWD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define LZWD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/lzwd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzwd_pkg
// Types and constants shared by the LZW dictionary block.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   localparam int START_BITS_DEF    = 9;
   localparam int FIRST_CODE_DEF    = 258;
   localparam int MAX_CODE_BITS_DEF = 12;
   localparam int MAX_STRING_DEF    = 64;

   localparam logic [3:0] MAX_LEN_RESET = 4'd12;

   typedef enum logic [2:0] {
      KIND_CLEAR  = 3'd0,
      KIND_LOOKUP = 3'd1,
      KIND_ADD    = 3'd2,
      KIND_TEST   = 3'd3,
      KIND_UNWIND = 3'd4
   } kind_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISS    = 2'd1;
   localparam logic [1:0] ST_TOOLONG = 2'd2;

   // Command passed from the front end to the back end through the queue.
   typedef struct packed {
      kind_type    kind;
      logic [11:0] prefix_code;
      logic        prefix_empty;
      logic [7:0]  symbol;
      logic [11:0] query_code;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

endpackage

@@ hdl/lzwd_front.sv @@
// ----------------------------------------------------------------------------
// lzwd_front
// Accepts items, drops unknown kinds and queues the rest for the back end.
// ----------------------------------------------------------------------------
module lzwd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [2:0]        req_tuser,
   input  logic [39:0]       req_tdata,
   output logic              q_valid,
   input  logic              q_pop,
   output lzwd_pkg::cmd_type q_cmd
);
   import lzwd_pkg::*;

   // Two-entry queue.
   cmd_type     mem_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   cmd_type     cmd;
   logic        push, known;

   always_comb begin
      cmd.kind         = kind_type'(req_tuser);
      cmd.prefix_code  = req_tdata[11:0];
      cmd.prefix_empty = req_tdata[12];
      cmd.symbol       = req_tdata[20:13];
      cmd.query_code   = req_tdata[32:21];
   end

   assign known      = (req_tuser <= KIND_UNWIND);
   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready && known;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_cmd      = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ (q_pop && q_valid);
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= cmd;
   end

endmodule

@@ hdl/lzwd_back.sv @@
// ----------------------------------------------------------------------------
// lzwd_back
// Executes dictionary commands against the entry memory and emits results.
// ----------------------------------------------------------------------------
module lzwd_back #(
   parameter int START_BITS    = lzwd_pkg::START_BITS_DEF,
   parameter int FIRST_CODE    = lzwd_pkg::FIRST_CODE_DEF,
   parameter int MAX_STRING    = lzwd_pkg::MAX_STRING_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [3:0]        max_len,
   input  logic              q_valid,
   output logic              q_pop,
   input  lzwd_pkg::cmd_type q_cmd,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   output logic              rsp_tlast
);
   import lzwd_pkg::*;

   localparam int MAX_CODE_BITS = MAX_CODE_BITS_DEF;
   localparam int TS  = 1 << MAX_CODE_BITS;
   localparam int CW  = MAX_CODE_BITS + 1;
   localparam int SPW = $clog2(MAX_STRING + 1);
   localparam int SIW = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_CHK   = 7'b0000100,
      S_WALK  = 7'b0001000,
      S_WCHK  = 7'b0010000,
      S_EMIT  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type st_ff, st_in;

   // Entry: empty flag, prefix, symbol.  Stored for codes at FIRST_CODE upward.
   logic [20:0] entry_mem [TS];
   logic [20:0] rd_ff;
   logic [MAX_CODE_BITS-1:0] raddr;
   logic        we;
   logic [7:0]  stack_mem [MAX_STRING];
   logic [7:0]  stk_rd_ff;

   logic [CW-1:0] next_ff, next_in;
   logic [3:0]    wid_ff, wid_in;
   logic          lock_ff, lock_in;
   cmd_type       cmd_ff, cmd_in;
   logic [CW-1:0] c_ff, c_in;
   logic [SPW-1:0] dep_ff, dep_in;
   logic          ov_ff, ov_in;
   logic [1:0]    ost_ff, ost_in;
   logic [11:0]   ocode_ff, ocode_in;
   logic [3:0]    olen_ff, olen_in;
   logic [7:0]    osym_ff, osym_in;
   logic          olast_ff, olast_in;
   logic          push_sym;
   logic [7:0]    push_data;
   logic [3:0]    emax;
   logic [20:0]   key;
   logic          c_present;

   always_comb begin
      emax = max_len;
      if (max_len < 4'(START_BITS))    emax = 4'(START_BITS);
      if (max_len > 4'(MAX_CODE_BITS)) emax = 4'(MAX_CODE_BITS);
   end

   assign key = cmd_ff.prefix_empty ? {1'b1, 12'd0, cmd_ff.symbol}
                                    : {1'b0, cmd_ff.prefix_code, cmd_ff.symbol};
   assign c_present = (c_ff < CW'(256)) ||
                      (c_ff >= CW'(FIRST_CODE) && c_ff < next_ff && c_ff < CW'(TS));
   assign we    = (st_ff == S_IDLE) && q_valid && q_cmd.kind == KIND_ADD &&
                  !lock_ff && next_ff < CW'(TS);
   assign raddr = c_in[MAX_CODE_BITS-1:0];
   assign push_data = (c_ff < CW'(256)) ? c_ff[7:0] : rd_ff[7:0];

   always_ff @(posedge clock) begin
      if (we) entry_mem[next_ff[MAX_CODE_BITS-1:0]] <=
            q_cmd.prefix_empty ? {1'b1, 12'd0, q_cmd.symbol}
                               : {1'b0, q_cmd.prefix_code, q_cmd.symbol};
      rd_ff <= entry_mem[raddr];
      if (push_sym) stack_mem[dep_ff[SIW-1:0]] <= push_data;
      // The top of the stack is written on the edge that moves to emitting.
      if (push_sym && st_in == S_EMIT) stk_rd_ff <= push_data;
      else stk_rd_ff <= stack_mem[dep_in[SIW-1:0] - SIW'(1)];
   end

   always_comb begin
      st_in = st_ff; next_in = next_ff; wid_in = wid_ff; lock_in = lock_ff;
      cmd_in = cmd_ff; c_in = c_ff; dep_in = dep_ff; ov_in = ov_ff;
      ost_in = ost_ff; ocode_in = ocode_ff; olen_in = olen_ff; osym_in = osym_ff;
      olast_in = olast_ff; q_pop = 1'b0; push_sym = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1; cmd_in = q_cmd;
               ost_in = ST_OK; ocode_in = '0; osym_in = '0; olast_in = 1'b1;
               olen_in = wid_ff; st_in = S_OUT;
               unique case (q_cmd.kind)
                  KIND_CLEAR: begin
                     next_in = CW'(FIRST_CODE); wid_in = 4'(START_BITS);
                     lock_in = 1'b0; olen_in = 4'(START_BITS);
                  end
                  KIND_LOOKUP: begin
                     c_in = next_ff; st_in = S_SCAN;
                  end
                  KIND_ADD: begin
                     if (!we) ost_in = ST_MISS;
                     else begin
                        ocode_in = next_ff[11:0];
                        next_in  = next_ff + CW'(1);
                        if (next_in > ((CW'(1) << wid_ff) - CW'(1))) begin
                           wid_in = wid_ff + 4'd1;
                           if (wid_in > emax) begin
                              lock_in = 1'b1; wid_in = emax;
                           end
                        end
                     end
                  end
                  KIND_TEST: begin
                     if (!((q_cmd.query_code < 12'd256) ||
                           ({1'b0, q_cmd.query_code} >= CW'(FIRST_CODE) &&
                            {1'b0, q_cmd.query_code} < next_ff)))
                        ost_in = ST_MISS;
                  end
                  default: begin
                     c_in = {1'b0, q_cmd.query_code}; dep_in = '0; st_in = S_WALK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Newest first: read code c-1, compare on the next cycle.
            if (c_ff > CW'(FIRST_CODE)) begin
               c_in = c_ff - CW'(1); st_in = S_CHK;
            end else begin
               if (cmd_ff.prefix_empty) ocode_in = {4'd0, cmd_ff.symbol};
               else ost_in = ST_MISS;
               st_in = S_OUT;
            end
         end
         S_CHK: begin
            if (rd_ff == key) begin
               ocode_in = c_ff[11:0]; st_in = S_OUT;
            end else if (c_ff > CW'(FIRST_CODE)) c_in = c_ff - CW'(1);
            else st_in = S_SCAN;
         end
         S_WALK: st_in = S_WCHK;   // read latency for code c
         S_WCHK: begin
            if (!c_present) begin
               ost_in = ST_MISS; st_in = S_OUT;
            end else if (dep_ff >= SPW'(MAX_STRING)) begin
               ost_in = ST_TOOLONG; st_in = S_OUT;
            end else begin
               push_sym = 1'b1; dep_in = dep_ff + SPW'(1);
               if (c_ff < CW'(256) || rd_ff[20]) begin
                  st_in = S_EMIT;
               end else begin
                  c_in = {1'b0, rd_ff[19:8]}; st_in = S_WALK;
               end
            end
         end
         S_EMIT: begin
            // Pop one symbol; stk_rd_ff holds the entry at dep_ff-1.
            osym_in = stk_rd_ff; olast_in = (dep_ff == SPW'(1));
            dep_in = dep_ff - SPW'(1); ov_in = 1'b1; st_in = S_OUT;
         end
         default: begin
            if (rsp_tready) begin
               if (ov_ff && !olast_ff) st_in = S_EMIT;
               else st_in = S_IDLE;
               if (!(ov_ff && !olast_ff)) ov_in = 1'b0;
            end
         end
      endcase
   end

   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tdata  = {5'd0, osym_ff, olen_ff, ocode_ff, ost_ff};
   assign rsp_tlast  = olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; next_ff <= CW'(FIRST_CODE); wid_ff <= 4'(START_BITS);
         lock_ff <= 1'b0; ov_ff <= 1'b0; dep_ff <= '0;
      end else begin
         st_ff <= st_in; next_ff <= next_in; wid_ff <= wid_in;
         lock_ff <= lock_in; ov_ff <= ov_in; dep_ff <= dep_in;
      end
      cmd_ff <= cmd_in; c_ff <= c_in; ost_ff <= ost_in; ocode_ff <= ocode_in;
      olen_ff <= olen_in; osym_ff <= osym_in; olast_ff <= olast_in;
   end

endmodule

@@ hdl/lzw_dictionary_table.sv @@
// ----------------------------------------------------------------------------
// lzw_dictionary_table
// LZW dictionary with variable code width: clear, lookup, add, test, unwind.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   req_*    in   tuser = kind; tdata = prefix_code, prefix_empty, symbol, query_code
//   rsp_*    out  status, result_code, code_length, out_symbol; tlast = last
//   csr_*    in   max_code_length
// Clear, add and test are answered straight from idle; lookup scans stored codes
// newest first, one code a cycle, until a match or the first stored code. Unwind
// follows prefix links to a root, then emits the symbols one result item each.
// Reset is synchronous; the roots are implicit, so no clearing pass is needed.
// A two-item queue lets the request side run ahead while results stall.
module lzw_dictionary_table #(
   parameter int START_BITS    = lzwd_pkg::START_BITS_DEF,
   parameter int FIRST_CODE    = lzwd_pkg::FIRST_CODE_DEF,
   parameter int MAX_STRING    = lzwd_pkg::MAX_STRING_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[2:0]
   input  logic [2:0]  req_tuser,
   // prefix_code[11:0], prefix_empty[12], symbol[20:13], query_code[32:21]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], result_code[13:2], code_length[17:14], out_symbol[25:18]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);
   import lzwd_pkg::*;

   logic [3:0] max_len_ff;
   logic       q_valid, q_pop;
   cmd_type    q_cmd;

   always_ff @(posedge clock) begin
      if (reset) max_len_ff <= MAX_LEN_RESET;
      else if (csr_we) max_len_ff <= csr_wdata;
   end

   lzwd_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .q_valid, .q_pop, .q_cmd
   );

   lzwd_back #(
      .START_BITS(START_BITS), .FIRST_CODE(FIRST_CODE), .MAX_STRING(MAX_STRING)
   ) u_back (
      .clock, .reset, .max_len(max_len_ff), .q_valid, .q_pop, .q_cmd,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

endmodule

@@ hdl/lzwd_checker.sv @@
// ----------------------------------------------------------------------------
// lzwd_checker
// Port-level checks on the dictionary block, bound to the top level.
// ----------------------------------------------------------------------------
`include "lzw_dictionary_table_assert.svh"

module lzwd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);
   `LZWD_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `LZWD_ASSERT_IMPL(a_len, clock, reset, rsp_tvalid, rsp_tdata[17:14] >= 4'd9 && rsp_tdata[17:14] <= 4'd12, "code length out of range")
   `LZWD_ASSERT_IMPL(a_status, clock, reset, rsp_tvalid, rsp_tdata[1:0] != 2'd3, "invalid status")
   `LZWD_ASSERT_IMPL(a_errlast, clock, reset, rsp_tvalid && rsp_tdata[1:0] != 2'd0, rsp_tlast && rsp_tdata[25:18] == 8'd0, "error result not final")
endmodule

bind lzw_dictionary_table lzwd_checker u_chk (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
);

@@ sim/tb_lzw_dictionary_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lzw_dictionary_table
// Self-checking bench for the LZW dictionary. Each accepted request item is run
// through a behavioural copy of the dictionary. Every result item is compared
// field by field with the oldest prediction. Directed tests cover the roots,
// reserved codes, hidden roots, broken and cyclic chains, the string length
// limit, width growth and locking. A random part then runs under several
// handshake idling patterns and register settings.
// ----------------------------------------------------------------------------
module tb_lzw_dictionary_table;
   import lzwd_pkg::*;

   localparam int TBL_SIZE = 1 << MAX_CODE_BITS_DEF;

   typedef struct {
      logic [2:0]  kind;
      logic [11:0] prefix;
      logic        empty;
      logic [7:0]  sym;
      logic [11:0] query;
   } dict_req_type;

   typedef struct {
      logic [1:0]  status;
      logic [11:0] code;
      logic [3:0]  len;
      logic [7:0]  sym;
      logic        last;
   } dict_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [3:0]  csr_wdata = '0;

   // Shadow copy of the dictionary state.
   logic [20:0] dict_entry [TBL_SIZE];
   int          next_code;
   int          cur_width;
   bit          locked;
   int          max_len;

   dict_rsp_type pending_rsp [$];
   int          mismatches = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;

   lzw_dictionary_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_max();
      if (max_len < START_BITS_DEF) return START_BITS_DEF;
      if (max_len > MAX_CODE_BITS_DEF) return MAX_CODE_BITS_DEF;
      return max_len;
   endfunction

   function automatic bit code_present(int c);
      if (c < 256) return 1'b1;
      return c >= FIRST_CODE_DEF && c < next_code && c < TBL_SIZE;
   endfunction

   function automatic void clear_dict();
      for (int i = 0; i < 256; i++) dict_entry[i] = {1'b1, 12'd0, i[7:0]};
      next_code = FIRST_CODE_DEF;
      cur_width = START_BITS_DEF;
      locked    = 1'b0;
   endfunction

   function automatic void push_rsp(logic [1:0] st, int code, int len, logic [7:0] sym,
                                    logic last);
      dict_rsp_type r;
      r.status = st;
      r.code   = code[11:0];
      r.len    = len[3:0];
      r.sym    = sym;
      r.last   = last;
      pending_rsp = {pending_rsp, r};
   endfunction

   function automatic void predict_dict(dict_req_type q);
      logic [20:0] key;
      logic [7:0]  stk [MAX_STRING_DEF];
      int          c;
      int          depth;
      int          code;
      bit          hit;
      key = q.empty ? {1'b1, 12'd0, q.sym} : {1'b0, q.prefix, q.sym};
      case (q.kind)
         KIND_CLEAR: begin
            clear_dict();
            push_rsp(ST_OK, 0, cur_width, 0, 1'b1);
         end
         KIND_LOOKUP: begin
            hit = 1'b0;
            for (c = next_code - 1; c >= FIRST_CODE_DEF && !hit; c--)
               if (c < TBL_SIZE && dict_entry[c] == key) begin
                  push_rsp(ST_OK, c, cur_width, 0, 1'b1);
                  hit = 1'b1;
               end
            if (!hit) begin
               if (q.empty) push_rsp(ST_OK, int'(q.sym), cur_width, 0, 1'b1);
               else push_rsp(ST_MISS, 0, cur_width, 0, 1'b1);
            end
         end
         KIND_ADD: begin
            if (locked || next_code >= TBL_SIZE) begin
               push_rsp(ST_MISS, 0, cur_width, 0, 1'b1);
            end else begin
               code = next_code;
               dict_entry[code] = key;
               push_rsp(ST_OK, code, cur_width, 0, 1'b1);
               next_code++;
               if (next_code > (1 << cur_width) - 1) begin
                  cur_width++;
                  if (cur_width > eff_max()) begin
                     locked    = 1'b1;
                     cur_width = eff_max();
                  end
               end
            end
         end
         KIND_TEST: begin
            push_rsp(code_present(int'(q.query)) ? ST_OK : ST_MISS, 0, cur_width, 0, 1'b1);
         end
         KIND_UNWIND: begin
            c = int'(q.query);
            depth = 0;
            forever begin
               if (!code_present(c)) begin
                  push_rsp(ST_MISS, 0, cur_width, 0, 1'b1);
                  return;
               end
               if (depth >= MAX_STRING_DEF) begin
                  push_rsp(ST_TOOLONG, 0, cur_width, 0, 1'b1);
                  return;
               end
               stk[depth] = dict_entry[c][7:0];
               depth++;
               if (dict_entry[c][20]) break;
               c = int'(dict_entry[c][19:8]);
            end
            for (int k = 0; k < depth; k++)
               push_rsp(ST_OK, 0, cur_width, stk[depth - 1 - k], k == depth - 1);
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input logic [2:0] kind, input int prefix, input int empty,
                            input int sym, input int query);
      dict_req_type q;
      q.kind   = kind;
      q.prefix = prefix[11:0];
      q.empty  = empty[0];
      q.sym    = sym[7:0];
      q.query  = query[11:0];
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tuser  <= q.kind;
      req_tdata  <= {7'd0, q.query, q.sym, q.empty, q.prefix};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_dict(q);
   endtask

   // Drops the request valid, waits for every predicted item and lets any
   // ignored request drain through the block.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_max_len(input int v);
      wait_idle();
      csr_wdata <= v[3:0];
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      max_len = v & 15;
   endtask

   function automatic int pick_code();
      if (next_code > FIRST_CODE_DEF && $urandom_range(1))
         return $urandom_range(next_code - 1, FIRST_CODE_DEF);
      return $urandom_range(255);
   endfunction

   task automatic fill_until(input int target);
      while (next_code < target && !locked)
         send_item(KIND_ADD, pick_code(), $urandom_range(1), $urandom, 0);
   endtask

   task automatic test_reset_state();
      send_item(KIND_TEST, 0, 0, 0, 255);
      send_item(KIND_TEST, 0, 0, 0, 256);
      send_item(KIND_TEST, 0, 0, 0, 257);
      send_item(KIND_TEST, 0, 0, 0, FIRST_CODE_DEF);
      send_item(KIND_LOOKUP, 0, 1, 0, 0);
      send_item(KIND_LOOKUP, 4095, 1, 255, 0);
      send_item(KIND_LOOKUP, 65, 0, 66, 0);
      send_item(KIND_UNWIND, 0, 0, 0, 0);
      send_item(KIND_UNWIND, 0, 0, 0, 257);
   endtask

   task automatic test_pairs();
      send_item(KIND_ADD, 65, 0, 66, 0);
      send_item(KIND_LOOKUP, 65, 0, 66, 0);
      send_item(KIND_ADD, 65, 0, 66, 0);
      send_item(KIND_LOOKUP, 65, 0, 66, 0);
      // A stored pair with the empty prefix hides the root for that byte.
      send_item(KIND_ADD, 0, 1, 7, 0);
      send_item(KIND_LOOKUP, 0, 1, 7, 0);
      send_item(KIND_UNWIND, 0, 0, 0, FIRST_CODE_DEF);
      send_item(KIND_TEST, 0, 0, 0, 4095);
      for (int k = 5; k < 8; k++) send_item(k[2:0], 4095, 1, 255, 4095);
   endtask

   task automatic test_broken_chains();
      send_item(KIND_ADD, 4000, 0, 1, 0);
      send_item(KIND_UNWIND, 0, 0, 0, next_code - 1);
      send_item(KIND_ADD, 256, 0, 2, 0);
      send_item(KIND_UNWIND, 0, 0, 0, next_code - 1);
      // An entry that names itself as prefix forms a cycle.
      send_item(KIND_ADD, next_code, 0, 3, 0);
      send_item(KIND_UNWIND, 0, 0, 0, next_code - 1);
      send_item(KIND_CLEAR, 0, 0, 0, 0);
   endtask

   task automatic test_string_limit();
      send_item(KIND_ADD, 0, 1, 1, 0);
      for (int i = 1; i < MAX_STRING_DEF; i++)
         send_item(KIND_ADD, next_code - 1, 0, i * 3, 0);
      send_item(KIND_UNWIND, 0, 0, 0, next_code - 1);
      send_item(KIND_ADD, next_code - 1, 0, 200, 0);
      send_item(KIND_UNWIND, 0, 0, 0, next_code - 1);
   endtask

   task automatic test_width_growth();
      // A limit below the start width is clamped, so the widening at code 512
      // locks the dictionary.
      write_max_len(0);
      fill_until(512);
      send_item(KIND_ADD, 1, 0, 1, 0);
      send_item(KIND_TEST, 0, 0, 0, 511);
      send_item(KIND_TEST, 0, 0, 0, 512);
      send_item(KIND_LOOKUP, 1, 0, 1, 0);
      write_max_len(15);
      send_item(KIND_CLEAR, 0, 0, 0, 0);
   endtask

   task automatic test_random();
      int idle_tab [4] = '{0, 83, 0, 31};
      int stall_tab [4] = '{0, 0, 83, 31};
      int max_tab [4] = '{12, 9, 10, 11};
      int count;
      int r;
      int c;
      for (int p = 0; p < 4; p++) begin
         write_max_len(max_tab[p]);
         idle_pct  = idle_tab[p];
         stall_pct = stall_tab[p];
         count = 0;
         while (count < 10) begin
            r = $urandom_range(99);
            count++;
            if (r < 4) begin
               send_item(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 8) begin
               send_item(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom, $urandom);
               count--;
            end else if (r < 35) begin
               if ($urandom_range(4) == 0)
                  send_item(KIND_ADD, $urandom, $urandom, $urandom, $urandom);
               else
                  send_item(KIND_ADD, pick_code(), int'($urandom_range(3) == 0),
                            $urandom, $urandom);
            end else if (r < 55) begin
               if (next_code > FIRST_CODE_DEF && $urandom_range(1)) begin
                  c = $urandom_range(next_code - 1, FIRST_CODE_DEF);
                  send_item(KIND_LOOKUP, int'(dict_entry[c][19:8]), int'(dict_entry[c][20]),
                            int'(dict_entry[c][7:0]), $urandom);
               end else begin
                  send_item(KIND_LOOKUP, pick_code(), $urandom, $urandom, $urandom);
               end
            end else if (r < 70) begin
               send_item(KIND_TEST, $urandom, $urandom, $urandom,
                         $urandom_range(3) == 0 ? $urandom : pick_code());
            end else begin
               send_item(KIND_UNWIND, $urandom, $urandom, $urandom,
                         $urandom_range(4) == 0 ? $urandom : pick_code());
            end
         end
      end
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      dict_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", rsp_tdata);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_tdata[1:0] !== e.status || rsp_tdata[13:2] !== e.code ||
                rsp_tdata[17:14] !== e.len || rsp_tdata[25:18] !== e.sym ||
                rsp_tlast !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected st %0d code %0d len %0d sym %0d last %0d, got st %0d code %0d len %0d sym %0d last %0d",
                           e.status, e.code, e.len, e.sym, e.last, rsp_tdata[1:0],
                           rsp_tdata[13:2], rsp_tdata[17:14], rsp_tdata[25:18], rsp_tlast);
            end
         end
      end
   end

   initial begin
      max_len = int'(MAX_LEN_RESET);
      clear_dict();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_pairs();
      test_broken_chains();
      test_string_limit();
      test_width_growth();
      test_random();
      wait_idle();
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("tb_lzw_dictionary_table passed");
      end else begin
         $display("tb_lzw_dictionary_table failed");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("tb_lzw_dictionary_table failed");
      $finish;
   end

endmodule
